@@ rtl/ptc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

  typedef logic [63:0] w64_t;

  // Calibration register indexes on the configuration port.
  typedef enum logic [1:0] {
    CFG_CAL_TEMP    = 2'd0,
    CFG_CAL_PRESS_A = 2'd1,
    CFG_CAL_PRESS_B = 2'd2,
    CFG_CAL_PRESS_C = 2'd3
  } cfg_idx_t;

  localparam int unsigned MUL_LAT   = 2;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;

  // Exact x / 10 for 32-bit x: (x * DIV10_MAGIC) >> 35.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  // Exact x / 100 for 24-bit x: (x * HPA_MAGIC) >> 32.
  localparam logic [25:0] HPA_MAGIC   = 26'd42949673;

  localparam w64_t T_OFFSET = 64'd128000;
  localparam w64_t P_FULL   = 64'd1048576;
  localparam w64_t P_SCALE  = 64'd3125;
  localparam w64_t P_BIAS   = 64'h0000_8000_0000_0000;

  function automatic w64_t sext16(input logic [15:0] v);
    sext16 = {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

@@ rtl/ptc_mul64.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Low 64 bits of a 64 x 64 product, built from 32 x 32 partial products.
module ptc_mul64 (
  input  wire logic          clk,
  input  wire ptc_pkg::w64_t a,
  input  wire ptc_pkg::w64_t b,
  output ptc_pkg::w64_t      y
);

  logic [63:0] lo_r;
  logic [31:0] cross_r;
  logic [63:0] y_r;

  always_ff @(posedge clk) begin
    lo_r    <= a[31:0] * b[31:0];
    cross_r <= a[63:32] * b[31:0] + a[31:0] * b[63:32];
    y_r     <= lo_r + {cross_r, 32'd0};
  end

  assign y = y_r;

endmodule
`default_nettype wire

@@ rtl/ptc_delay.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Fixed-length shift line that keeps side data aligned with the pipeline.
module ptc_delay #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic [W-1:0]      q
);

  logic [W-1:0] line_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    line_r[0] <= d;
    for (int unsigned i = 1; i < DEPTH; i++) begin
      line_r[i] <= line_r[i-1];
    end
  end

  assign q = line_r[DEPTH-1];

endmodule
`default_nettype wire

@@ rtl/ptc_sdiv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Truncating signed 64-bit division, one quotient bit per pipeline stage.
module ptc_sdiv (
  input  wire logic          clk,
  input  wire ptc_pkg::w64_t num,
  input  wire ptc_pkg::w64_t den,
  output ptc_pkg::w64_t      quo
);

  localparam int unsigned N = ptc_pkg::DIV_STEPS;

  logic [63:0] rem_r [0:N];
  logic [63:0] num_r [0:N];
  logic [63:0] den_r [0:N];
  logic        neg_r [0:N];
  logic [63:0] quo_r;

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    num_r[0] <= num[63] ? (64'd0 - num) : num;
    den_r[0] <= den[63] ? (64'd0 - den) : den;
    neg_r[0] <= num[63] ^ den[63];
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [64:0] sh_nxt;
    logic        ge_nxt;
    logic [64:0] diff_nxt;
    assign sh_nxt   = {rem_r[i], num_r[i][63]};
    assign diff_nxt = sh_nxt - {1'b0, den_r[i]};
    assign ge_nxt   = !diff_nxt[64];
    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge_nxt ? diff_nxt[63:0] : sh_nxt[63:0];
      num_r[i+1] <= {num_r[i][62:0], ge_nxt};
      den_r[i+1] <= den_r[i];
      neg_r[i+1] <= neg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= neg_r[N] ? (64'd0 - num_r[N]) : num_r[N];
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

@@ rtl/pressure_temp_compensation.sv @@
// Each request that is accepted at a clock edge gives its own result strobe.
// Throughput: one request per cycle; busy stays low, so start is always taken.
// The 64-stage bit-per-stage pressure divider sets most of the latency.
// Reset (synchronous, rst_n low) empties the pipeline and clears the calibration to zero.
// The receiver cannot stall, so nothing in the datapath ever waits.
`timescale 1ns / 1ps
`default_nettype none
module pressure_temp_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [19:0] in_adc_temp,
  input  wire logic [19:0] in_adc_press,
  output logic             out_strobe,
  output logic signed [31:0] out_temp_centi,
  output logic signed [15:0] out_temp_deci,
  output logic [31:0]      out_pressure_q24_8,
  output logic [15:0]      out_pressure_hpa,
  output logic             out_div_zero,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  // Stage numbers below count register stages after the accepting edge.
  localparam int unsigned LAT = 87;

  // Calibration is to be written only while the pipeline is empty, so every stage
  // reads it directly; the user must keep to this, as the block does not enforce it.
  logic [47:0] cal_temp_r;
  logic [63:0] cal_press_a_r;
  logic [63:0] cal_press_b_r;
  logic [15:0] cal_press_c_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r    <= '0;
      cal_press_a_r <= '0;
      cal_press_b_r <= '0;
      cal_press_c_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (ptc_pkg::cfg_idx_t'(cfg_index))
        ptc_pkg::CFG_CAL_TEMP:    cal_temp_r    <= cfg_data[47:0];
        ptc_pkg::CFG_CAL_PRESS_A: cal_press_a_r <= cfg_data;
        ptc_pkg::CFG_CAL_PRESS_B: cal_press_b_r <= cfg_data;
        ptc_pkg::CFG_CAL_PRESS_C: cal_press_c_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data; the output strobe is the last one.
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start && !busy};
    end
  end

  assign out_strobe = vld_r[LAT-1];

  // Calibration words.
  logic [15:0]   t1_w;
  logic [31:0]   t2_w;
  logic [31:0]   t3_w;
  ptc_pkg::w64_t p1_w, p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;

  assign t1_w = cal_temp_r[15:0];
  assign t2_w = {{16{cal_temp_r[31]}}, cal_temp_r[31:16]};
  assign t3_w = {{16{cal_temp_r[47]}}, cal_temp_r[47:32]};
  assign p1_w = {48'd0, cal_press_a_r[15:0]};
  assign p2_w = ptc_pkg::sext16(cal_press_a_r[31:16]);
  assign p3_w = ptc_pkg::sext16(cal_press_a_r[47:32]);
  assign p4_w = ptc_pkg::sext16(cal_press_a_r[63:48]);
  assign p5_w = ptc_pkg::sext16(cal_press_b_r[15:0]);
  assign p6_w = ptc_pkg::sext16(cal_press_b_r[31:16]);
  assign p7_w = ptc_pkg::sext16(cal_press_b_r[47:32]);
  assign p8_w = ptc_pkg::sext16(cal_press_b_r[63:48]);
  assign p9_w = ptc_pkg::sext16(cal_press_c_r);

  // Temperature path, 32-bit wrapping arithmetic, plus the 64-bit v1_r that opens the pressure path.
  logic [31:0] x1_r, d_r;            // stage 1
  logic [31:0] m1_r, dd_r;           // stage 2
  logic [31:0] e1_r, m2_r;           // stage 3
  logic [31:0] tf_r;                 // stage 4
  logic [31:0] tc_r;                 // stage 5
  ptc_pkg::w64_t v1_r;               // stage 5

  logic [31:0] m1_nxt, dd_nxt, e1_nxt, sq_nxt, m2_nxt, tf_nxt, tm_nxt, tc_nxt;

  assign m1_nxt = x1_r * t2_w;
  assign dd_nxt = d_r * d_r;
  assign e1_nxt = $signed(m1_r) >>> 11;
  assign sq_nxt = $signed(dd_r) >>> 12;
  assign m2_nxt = sq_nxt * t3_w;
  assign tf_nxt = e1_r + 32'($signed(m2_r) >>> 14);
  assign tm_nxt = tf_r * 32'd5 + 32'd128;
  assign tc_nxt = $signed(tm_nxt) >>> 8;

  always_ff @(posedge clk) begin
    x1_r <= {15'd0, in_adc_temp[19:3]} - {15'd0, t1_w, 1'b0};
    d_r  <= {16'd0, in_adc_temp[19:4]} - {16'd0, t1_w};
    m1_r <= m1_nxt;
    dd_r <= dd_nxt;
    e1_r <= e1_nxt;
    m2_r <= m2_nxt;
    tf_r <= tf_nxt;
    tc_r <= tc_nxt;
    v1_r <= {{32{tf_r[31]}}, tf_r} - ptc_pkg::T_OFFSET;
  end

  // Tenths of a degree: magnitude, reciprocal multiply, sign restore.
  logic [31:0] mag_r, q10_r;
  logic        tneg6_r, tneg7_r;
  logic [15:0] td_r;
  logic [63:0] q10_prod;

  assign q10_prod = mag_r * ptc_pkg::DIV10_MAGIC;

  always_ff @(posedge clk) begin
    mag_r   <= tc_r[31] ? (32'd0 - tc_r) : tc_r;
    tneg6_r <= tc_r[31];
    q10_r   <= {3'd0, q10_prod[63:35]};
    tneg7_r <= tneg6_r;
    td_r    <= tneg7_r ? 16'(32'd0 - q10_r) : q10_r[15:0];
  end

  // Pressure path, 64-bit wrapping arithmetic.
  ptc_pkg::w64_t v1sq, v1p5, v1p2, a6, a3, v1p5_d, v1p2_d;

  ptc_mul64 u_mul_sq (.clk(clk), .a(v1_r), .b(v1_r), .y(v1sq));
  ptc_mul64 u_mul_p5 (.clk(clk), .a(v1_r), .b(p5_w), .y(v1p5));
  ptc_mul64 u_mul_p2 (.clk(clk), .a(v1_r), .b(p2_w), .y(v1p2));
  ptc_mul64 u_mul_p6 (.clk(clk), .a(v1sq), .b(p6_w), .y(a6));
  ptc_mul64 u_mul_p3 (.clk(clk), .a(v1sq), .b(p3_w), .y(a3));

  ptc_delay #(.W(64), .DEPTH(ptc_pkg::MUL_LAT)) u_dly_p5 (.clk(clk), .d(v1p5), .q(v1p5_d));
  ptc_delay #(.W(64), .DEPTH(ptc_pkg::MUL_LAT)) u_dly_p2 (.clk(clk), .d(v1p2), .q(v1p2_d));

  // Raw pressure is needed at stage 10 to form the dividend.
  logic [19:0] ap_d;
  ptc_delay #(.W(20), .DEPTH(10)) u_dly_ap (.clk(clk), .d(in_adc_press), .q(ap_d));

  ptc_pkg::w64_t v2_r, v1b_r, x_r, nb_r, y_p1, n_k, v1f_r, n_r;
  ptc_pkg::w64_t praw_w;

  assign praw_w = ptc_pkg::P_FULL - {44'd0, ap_d};

  always_ff @(posedge clk) begin
    v2_r  <= a6 + (v1p5_d << 17) + (p4_w << 35);
    v1b_r <= 64'($signed(a3) >>> 8) + (v1p2_d << 12);
    x_r   <= ptc_pkg::P_BIAS + v1b_r;
    nb_r  <= (praw_w << 31) - v2_r;
  end

  ptc_mul64 u_mul_p1 (.clk(clk), .a(x_r),  .b(p1_w),             .y(y_p1));
  ptc_mul64 u_mul_sc (.clk(clk), .a(nb_r), .b(ptc_pkg::P_SCALE), .y(n_k));

  always_ff @(posedge clk) begin
    v1f_r <= $signed(y_p1) >>> 33;
    n_r   <= n_k;
  end

  // Stage 14 feeds the divider; the quotient appears at stage 80.
  ptc_pkg::w64_t pdiv;
  ptc_sdiv u_sdiv (.clk(clk), .num(n_r), .den(v1f_r), .quo(pdiv));

  // A zero divisor is caught before the divider and rides along to stage 86.
  logic dz_d;
  ptc_delay #(.W(1), .DEPTH(71)) u_dly_dz (.clk(clk), .d(v1f_r == 64'd0), .q(dz_d));

  ptc_pkg::w64_t h_w, hh, pp8, a9, pp8_d, p_d;

  assign h_w = $signed(pdiv) >>> 13;

  ptc_mul64 u_mul_hh (.clk(clk), .a(h_w),  .b(h_w),  .y(hh));
  ptc_mul64 u_mul_p8 (.clk(clk), .a(pdiv), .b(p8_w), .y(pp8));
  ptc_mul64 u_mul_p9 (.clk(clk), .a(hh),   .b(p9_w), .y(a9));

  ptc_delay #(.W(64), .DEPTH(ptc_pkg::MUL_LAT)) u_dly_p8 (.clk(clk), .d(pp8), .q(pp8_d));
  ptc_delay #(.W(64), .DEPTH(2 * ptc_pkg::MUL_LAT)) u_dly_p (.clk(clk), .d(pdiv), .q(p_d));

  ptc_pkg::w64_t s_r, pf_w;
  logic [31:0]   pq_r;

  assign pf_w = 64'($signed(s_r) >>> 8) + (p7_w << 4);

  always_ff @(posedge clk) begin
    s_r  <= p_d + 64'($signed(a9) >>> 25) + 64'($signed(pp8_d) >>> 19);
    pq_r <= dz_d ? 32'd0 : pf_w[31:0];
  end

  // Temperature results wait for the pressure to arrive at stage 86.
  logic [31:0] tc_d;
  logic [15:0] td_d;
  logic        dz86_r;

  ptc_delay #(.W(32), .DEPTH(81)) u_dly_tc (.clk(clk), .d(tc_r), .q(tc_d));
  ptc_delay #(.W(16), .DEPTH(78)) u_dly_td (.clk(clk), .d(td_r), .q(td_d));

  always_ff @(posedge clk) begin
    dz86_r <= dz_d;
  end

  // Hectopascals: q24.8 / 25600 is the integer part divided by 100.
  logic [49:0] hpa_prod;
  assign hpa_prod = pq_r[31:8] * ptc_pkg::HPA_MAGIC;

  always_ff @(posedge clk) begin
    out_temp_centi     <= tc_d;
    out_temp_deci      <= td_d;
    out_pressure_q24_8 <= pq_r;
    out_pressure_hpa   <= hpa_prod[47:32];
    out_div_zero       <= dz86_r;
  end

  // A result strobe always traces back to an accepted request.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result strobe without a matching request");

  // A zero divisor forces both pressure fields to zero.
  a_div_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_div_zero) |-> (out_pressure_q24_8 == 32'd0 && out_pressure_hpa == 16'd0))
    else $error("pressure not cleared on zero divisor");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire

@@ tb/pressure_temp_compensation_tb.sv @@
`timescale 1ns / 1ps
module pressure_temp_compensation_tb;

  // One compensated reading, as the block presents it on its result ports.
  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic signed [15:0] temp_deci;
    logic [31:0]        pressure_q24_8;
    logic [15:0]        pressure_hpa;
    logic               div_zero;
  } reading_t;

  // A row of the directed table. Rows marked typed carry their expected
  // reading; the others are checked against the predictor.
  typedef struct {
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
    bit          typed;
    reading_t    reading;
  } sample_row_t;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 220;
  // Rows before this index run with the calibration still at its reset value.
  localparam int unsigned FIRST_CAL_ROW = 4;
  localparam reading_t    RESET_READING = '{32'sd0, 16'sd0, 32'd0, 16'd0, 1'b1};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [19:0] in_adc_temp;
  logic [19:0] in_adc_press;
  logic        out_strobe;
  logic signed [31:0] out_temp_centi;
  logic signed [15:0] out_temp_deci;
  logic [31:0] out_pressure_q24_8;
  logic [15:0] out_pressure_hpa;
  logic        out_div_zero;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  // The testbench's own copy of the calibration words.
  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_a_q;
  logic [63:0] cal_press_b_q;
  logic [15:0] cal_press_c_q;

  reading_t    pending_readings[$];
  int unsigned cycles;
  bit          failed;
  bit          steady_sender;

  pressure_temp_compensation uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_adc_temp       (in_adc_temp),
    .in_adc_press      (in_adc_press),
    .out_strobe        (out_strobe),
    .out_temp_centi    (out_temp_centi),
    .out_temp_deci     (out_temp_deci),
    .out_pressure_q24_8(out_pressure_q24_8),
    .out_pressure_hpa  (out_pressure_hpa),
    .out_div_zero      (out_div_zero),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Arithmetic right shifts on raw bit patterns, as the compensation uses them.
  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned sh);
    return $unsigned($signed(x) >>> sh);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned sh);
    return $unsigned($signed(x) >>> sh);
  endfunction

  function automatic logic [63:0] widen16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Signed division truncating toward zero; the most negative value divided
  // by minus one wraps back to itself.
  function automatic logic [63:0] quot_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = n[63] ? 64'd0 - n : n;
    md = d[63] ? 64'd0 - d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? 64'd0 - q : q;
  endfunction

  // Predicts the reading for one pair of raw samples under the current
  // calibration. The temperature part wraps at 32 bits, the pressure at 64.
  function automatic reading_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
    logic [31:0] a, t1, t2, t3, e1, dt, e2, tfine, tc, mag, q10;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, p, h, w1, w2;
    reading_t    r;
    a  = {12'd0, raw_t};
    t1 = {16'd0, cal_temp_q[15:0]};
    t2 = {{16{cal_temp_q[31]}}, cal_temp_q[31:16]};
    t3 = {{16{cal_temp_q[47]}}, cal_temp_q[47:32]};
    p1 = {48'd0, cal_press_a_q[15:0]};
    p2 = widen16(cal_press_a_q[31:16]);
    p3 = widen16(cal_press_a_q[47:32]);
    p4 = widen16(cal_press_a_q[63:48]);
    p5 = widen16(cal_press_b_q[15:0]);
    p6 = widen16(cal_press_b_q[31:16]);
    p7 = widen16(cal_press_b_q[47:32]);
    p8 = widen16(cal_press_b_q[63:48]);
    p9 = widen16(cal_press_c_q);

    e1    = sra32(((a >> 3) - (t1 << 1)) * t2, 11);
    dt    = (a >> 4) - t1;
    e2    = sra32(sra32(dt * dt, 12) * t3, 14);
    tfine = e1 + e2;
    tc    = sra32(tfine * 32'd5 + 32'd128, 8);
    mag   = tc[31] ? 32'd0 - tc : tc;
    q10   = mag / 32'd10;
    r.temp_centi = tc;
    r.temp_deci  = tc[31] ? 16'(32'd0 - q10) : 16'(q10);

    v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64((64'h0000_8000_0000_0000 + v1) * p1, 33);

    if (v1 == 64'd0) begin
      r.pressure_q24_8 = 32'd0;
      r.div_zero       = 1'b1;
    end else begin
      p  = 64'd1048576 - {44'd0, raw_p};
      p  = quot_trunc(((p << 31) - v2) * 64'd3125, v1);
      h  = sra64(p, 13);
      w1 = sra64(p9 * h * h, 25);
      w2 = sra64(p8 * p, 19);
      p  = sra64(p + w1 + w2, 8) + (p7 << 4);
      r.pressure_q24_8 = p[31:0];
      r.div_zero       = 1'b0;
    end
    r.pressure_hpa = 16'(r.pressure_q24_8 / 32'd25600);
    return r;
  endfunction

  // Writes one calibration register and mirrors it in the local copy.
  task automatic write_cal(input ptc_pkg::cfg_idx_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ptc_pkg::CFG_CAL_TEMP:    cal_temp_q    = value[47:0];
      ptc_pkg::CFG_CAL_PRESS_A: cal_press_a_q = value;
      ptc_pkg::CFG_CAL_PRESS_B: cal_press_b_q = value;
      ptc_pkg::CFG_CAL_PRESS_C: cal_press_c_q = value[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Presents one request and holds it until the block takes it. The sender
  // then idles for a random number of cycles unless it is in a steady run.
  task automatic send_sample(input logic [19:0] raw_t, input logic [19:0] raw_p,
                             input bit typed, input reading_t typed_reading);
    int unsigned gap;
    start        <= 1'b1;
    in_adc_temp  <= raw_t;
    in_adc_press <= raw_p;
    do @(posedge clk); while (busy);
    pending_readings.push_back(typed ? typed_reading : compensate(raw_t, raw_p));
    gap = steady_sender ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops the sender and waits until every outstanding reading has come back.
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  // Loads a whole calibration set for one phase of the random part. The first
  // kinds are the extremes; the rest are near a typical part or fully random.
  task automatic load_calibration(input int unsigned kind);
    logic [63:0] ct, ca, cb, cc;
    case (kind)
      0: begin
        ct = 64'h0;
        ca = 64'h0;
        cb = 64'h0;
        cc = 64'h0;
      end
      1: begin
        ct = '1;
        ca = '1;
        cb = '1;
        cc = '1;
      end
      2: begin
        ct = 64'h0000_8000_8000_8000;
        ca = 64'h8000_8000_8000_8000;
        cb = 64'h8000_8000_8000_8000;
        cc = 64'hFFFF_FFFF_FFFF_8000;
      end
      3: begin
        ct = 64'h0000_7FFF_7FFF_FFFF;
        ca = 64'h7FFF_7FFF_7FFF_FFFF;
        cb = 64'h7FFF_7FFF_7FFF_7FFF;
        cc = 64'h0000_0000_0000_7FFF;
      end
      4, 5: begin
        // A typical part with some spread on every word.
        ct = {16'h0, 16'(-1000 + $urandom_range(0, 200)),
              16'(26435 + $urandom_range(0, 200)), 16'(27504 + $urandom_range(0, 200))};
        ca = {16'(2855 + $urandom_range(0, 100)), 16'(3024 + $urandom_range(0, 100)),
              16'(-10685 + $urandom_range(0, 100)), 16'(36477 + $urandom_range(0, 200))};
        cb = {16'(-14600 + $urandom_range(0, 100)), 16'(15500 + $urandom_range(0, 100)),
              16'(-7 + $urandom_range(0, 14)), 16'(140 + $urandom_range(0, 20))};
        cc = {$urandom, 16'($urandom), 16'(6000 + $urandom_range(0, 100))};
      end
      default: begin
        ct = {$urandom, $urandom};
        ca = {$urandom, $urandom};
        cb = {$urandom, $urandom};
        cc = {$urandom, $urandom};
      end
    endcase
    write_cal(ptc_pkg::CFG_CAL_TEMP, ct);
    write_cal(ptc_pkg::CFG_CAL_PRESS_A, ca);
    write_cal(ptc_pkg::CFG_CAL_PRESS_B, cb);
    write_cal(ptc_pkg::CFG_CAL_PRESS_C, cc);
  endtask

  // Mostly readings in the normal operating span, with extremes mixed in.
  function automatic logic [19:0] raw_reading(input logic [19:0] centre);
    case ($urandom_range(0, 9))
      0:       return 20'd0;
      1:       return 20'hFFFFF;
      2, 3:    return 20'($urandom);
      default: return centre - 20'd60000 + 20'($urandom_range(0, 120000));
    endcase
  endfunction

  // Every result strobe is compared with the oldest expected reading.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_strobe) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        failed = 1'b1;
      end else begin
        want = pending_readings.pop_front();
        if (out_temp_centi !== want.temp_centi) begin
          $display("%0t: temp_centi expected %0d got %0d", $time, want.temp_centi,
                   out_temp_centi);
          failed = 1'b1;
        end
        if (out_temp_deci !== want.temp_deci) begin
          $display("%0t: temp_deci expected %0d got %0d", $time, want.temp_deci,
                   out_temp_deci);
          failed = 1'b1;
        end
        if (out_pressure_q24_8 !== want.pressure_q24_8) begin
          $display("%0t: pressure_q24_8 expected %h got %h", $time, want.pressure_q24_8,
                   out_pressure_q24_8);
          failed = 1'b1;
        end
        if (out_pressure_hpa !== want.pressure_hpa) begin
          $display("%0t: pressure_hpa expected %0d got %0d", $time, want.pressure_hpa,
                   out_pressure_hpa);
          failed = 1'b1;
        end
        if (out_div_zero !== want.div_zero) begin
          $display("%0t: div_zero expected %b got %b", $time, want.div_zero, out_div_zero);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: a run that is this long has hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sample_row_t rows[$];
    rst_n         = 1'b0;
    start         = 1'b0;
    in_adc_temp   = 20'd0;
    in_adc_press  = 20'd0;
    cfg_valid     = 1'b0;
    cfg_index     = ptc_pkg::CFG_CAL_TEMP;
    cfg_data      = 64'd0;
    cal_temp_q    = '0;
    cal_press_a_q = '0;
    cal_press_b_q = '0;
    cal_press_c_q = '0;
    cycles        = 0;
    failed        = 1'b0;
    steady_sender = 1'b0;

    // With the calibration cleared, the fine temperature is zero and the
    // pressure divisor is zero, whatever the raw samples are.
    rows = '{
      '{20'h00000, 20'h00000, 1'b1, RESET_READING},
      '{20'hFFFFF, 20'hFFFFF, 1'b1, RESET_READING},
      '{20'hFFFFF, 20'h00000, 1'b1, RESET_READING},
      '{20'h00000, 20'hFFFFF, 1'b1, RESET_READING},
      // From here on a typical calibration is loaded and the predictor decides.
      '{20'd519888, 20'd415148, 1'b0, RESET_READING},
      '{20'h00000, 20'h00000, 1'b0, RESET_READING},
      '{20'hFFFFF, 20'hFFFFF, 1'b0, RESET_READING},
      '{20'h80000, 20'h80000, 1'b0, RESET_READING},
      '{20'h7FFFF, 20'h7FFFF, 1'b0, RESET_READING},
      '{20'h00001, 20'hFFFFE, 1'b0, RESET_READING},
      '{20'hAAAAA, 20'h55555, 1'b0, RESET_READING},
      '{20'h55555, 20'hAAAAA, 1'b0, RESET_READING},
      '{20'd430000, 20'd300000, 1'b0, RESET_READING},
      '{20'd600000, 20'd500000, 1'b0, RESET_READING}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (i == FIRST_CAL_ROW) begin
        drain();
        write_cal(ptc_pkg::CFG_CAL_TEMP, 64'h0000_FC18_6743_6B70);
        write_cal(ptc_pkg::CFG_CAL_PRESS_A, 64'h0B27_0BD0_D653_8E7D);
        write_cal(ptc_pkg::CFG_CAL_PRESS_B, 64'hC6F8_3C8C_FFF9_008C);
        write_cal(ptc_pkg::CFG_CAL_PRESS_C, 64'h0000_0000_0000_1770);
      end
      send_sample(rows[i].adc_temp, rows[i].adc_press, rows[i].typed, rows[i].reading);
    end

    // Random phases, each under its own calibration. The sender switches
    // between idling and back-to-back runs, and now and then waits for the
    // pipeline to empty completely before going on.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      load_calibration(ph);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) steady_sender = $urandom_range(0, 2) == 0;
        if ($urandom_range(0, 99) == 0) drain();
        send_sample(raw_reading(20'd519888), raw_reading(20'd415148), 1'b0, RESET_READING);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
